/* design/i2cm_pkg.sv */
// Shared types, command codes and helpers for the I2C master bit engine.
// No dependencies; every other design file except i2cm_if imports this package.
package i2cm_pkg;

   // Command codes as carried on the request channel
   localparam logic [2:0] CMD_NONE  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [3:0]  BYTE_BITS      = 4'd8;
   localparam logic [15:0] HALF_BIT_RESET = 16'd100;

   // One decoded tick as it sits in the queue
   typedef struct packed {
      logic [2:0] command;
      logic [7:0] write_data;
      logic       ack_bit;
      logic       scl_in;
      logic       sda_in;
   } tick_type;

   // Queue status seen by the front and back ends
   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // SDA pull-down for the start of a bit slot: data bits come from the
   // shift register MSB, the acknowledge slot from the stored ACK bit.
   function automatic logic bit_sda_low(input logic [3:0] bit_count,
                                        input logic [7:0] shift,
                                        input logic       is_read,
                                        input logic       ack_send);
      logic data_slot;
      logic written;
      logic value;
      data_slot = (bit_count < BYTE_BITS);
      written   = data_slot != is_read;
      value     = data_slot ? shift[7] : ack_send;
      return written & ~value;
   endfunction

endpackage

/* design/i2cm_if.sv */
// Channel interfaces of the I2C master bit engine: request, response, CSR.
// No dependencies.
interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] write_data;
   logic       ack_bit;
   logic       scl_in;
   logic       sda_in;
   modport source (output valid, command, write_data, ack_bit, scl_in, sda_in,
                   input ready);
   modport sink   (input valid, command, write_data, ack_bit, scl_in, sda_in,
                   output ready);
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_drive_low;
   logic       sda_drive_low;
   logic       busy_res;
   logic       done_res;
   logic [7:0] read_data;
   logic       nack_received;
   logic       arb_lost;
   modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                   read_data, nack_received, arb_lost, input ready);
   modport sink   (input valid, scl_drive_low, sda_drive_low, busy_res, done_res,
                   read_data, nack_received, arb_lost, output ready);
endinterface

interface i2cm_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] half_bit_ticks;
   modport source (output valid, half_bit_ticks, input ready);
   modport sink   (input valid, half_bit_ticks, output ready);
endinterface

/* design/i2c_master_bit_engine.sv */
// Top level of the I2C master bit engine: front end, tick queue, back end.
// Depends on i2cm_pkg, i2cm_if, i2cm_front, i2cm_queue and i2cm_back.
//
// Usage: every request word on req_ch is one timing tick carrying the sampled
// SCL/SDA levels and an optional command (start, stop, write byte, read
// byte), which is taken only while the engine is idle. Every request word
// yields exactly one response word on rsp_ch with the line drives, busy,
// done, last read byte, last acknowledge and an arbitration-lost pulse.
// csr_ch writes the half-bit tick count (reset value 100); it is always
// ready and should only be written while the engine is idle.
// A response word is registered: its request word lands in the tick queue
// when accepted, and the sequencer steps it from the queue head into the
// output register once the output register can take a word.
// Throughput: one word per cycle, one sequencer step per tick, while rsp_ch does not stall.
// Reset (synchronous, active high) releases both lines, clears the state
// and empties the queue. When the response side stalls, the output word is
// held and up to QUEUE_DEPTH request words are still taken before
// req_ch.ready drops.
module i2c_master_bit_engine #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   i2cm_req_if.sink    req_ch,
   i2cm_rsp_if.source  rsp_ch,
   i2cm_csr_if.sink    csr_ch
);
   import i2cm_pkg::*;

   logic         push;
   logic         pop;
   tick_type     push_tick;
   tick_type     head_tick;
   q_status_type q_status;

   i2cm_front u_front (
      .req_ch    (req_ch),
      .q_status  (q_status),
      .push      (push),
      .push_tick (push_tick)
   );

   i2cm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_tick (push_tick),
      .pop       (pop),
      .head_tick (head_tick),
      .q_status  (q_status)
   );

   i2cm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_ch    (csr_ch),
      .rsp_ch    (rsp_ch),
      .head_tick (head_tick),
      .q_status  (q_status),
      .pop       (pop)
   );

endmodule

/* design/i2cm_front.sv */
// Front end: takes request words, normalizes the command code, pushes the
// decoded tick into the queue. Depends on i2cm_pkg and i2cm_if.
module i2cm_front (
   i2cm_req_if.sink              req_ch,
   input  i2cm_pkg::q_status_type q_status,
   output logic                  push,
   output i2cm_pkg::tick_type    push_tick
);
   import i2cm_pkg::*;

   logic [2:0] cmd_norm;

   // Undefined command codes collapse to "none"
   always_comb begin
      case (req_ch.command)
         CMD_START: cmd_norm = CMD_START;
         CMD_STOP:  cmd_norm = CMD_STOP;
         CMD_WRITE: cmd_norm = CMD_WRITE;
         CMD_READ:  cmd_norm = CMD_READ;
         default:   cmd_norm = CMD_NONE;
      endcase
   end

   assign req_ch.ready = ~q_status.full;
   assign push         = req_ch.valid & ~q_status.full;

   always_comb begin
      push_tick.command    = cmd_norm;
      push_tick.write_data = req_ch.write_data;
      push_tick.ack_bit    = req_ch.ack_bit;
      push_tick.scl_in     = req_ch.scl_in;
      push_tick.sda_in     = req_ch.sda_in;
   end

endmodule

/* design/i2cm_queue.sv */
// Small FIFO of decoded ticks between front and back ends.
// Depends on i2cm_pkg.
module i2cm_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  i2cm_pkg::tick_type     push_tick,
   input  logic                   pop,
   output i2cm_pkg::tick_type     head_tick,
   output i2cm_pkg::q_status_type q_status
);
   import i2cm_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   tick_type        mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == FULL_CNT);
   assign head_tick      = mem_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_tick;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full)) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && q_status.empty)) else $error("queue pop while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT) else $error("queue fill count out of range");

endmodule

/* design/i2cm_back.sv */
// Back end: I2C bit sequencer stepped once per tick, CSR register and the
// response output register. Depends on i2cm_pkg and i2cm_if.
module i2cm_back (
   input  logic                   clock,
   input  logic                   reset,
   i2cm_csr_if.sink               csr_ch,
   i2cm_rsp_if.source             rsp_ch,
   input  i2cm_pkg::tick_type     head_tick,
   input  i2cm_pkg::q_status_type q_status,
   output logic                   pop
);
   import i2cm_pkg::*;

   // Sequencer states
   localparam logic [3:0] PH_IDLE     = 4'd0;
   localparam logic [3:0] PH_RS_REL   = 4'd1;
   localparam logic [3:0] PH_RS_WAIT  = 4'd2;
   localparam logic [3:0] PH_RS_SETUP = 4'd3;
   localparam logic [3:0] PH_ST_HOLD  = 4'd4;
   localparam logic [3:0] PH_SP_LOW   = 4'd5;
   localparam logic [3:0] PH_SP_WAIT  = 4'd6;
   localparam logic [3:0] PH_SP_SETUP = 4'd7;
   localparam logic [3:0] PH_SP_HIGH  = 4'd8;
   localparam logic [3:0] PH_SP_END   = 4'd9;
   localparam logic [3:0] PH_BIT_SET  = 4'd10;
   localparam logic [3:0] PH_BIT_WAIT = 4'd11;
   localparam logic [3:0] PH_BIT_HOLD = 4'd12;

   logic [15:0] half_ticks_ff;
   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  bit_count_ff, bit_count_in;
   logic [7:0]  shift_ff, shift_in;
   logic [15:0] delay_ff, delay_in;
   logic        open_ff, open_in;
   logic        scl_low_ff, scl_low_in;
   logic        sda_low_ff, sda_low_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic        ack_seen_ff, ack_seen_in;
   logic        is_read_ff, is_read_in;
   logic        ack_send_ff, ack_send_in;
   logic        done_in, arb_in;

   logic [15:0] n_eff;
   logic        dly_done;
   logic [15:0] dly_next;
   logic        data_slot;
   logic        slot_written;
   logic        slot_value;

   // Output register
   logic        rsp_valid_ff;
   logic        busy_ff, done_ff, arb_ff;

   assign csr_ch.ready = 1'b1;

   // The queue head is stepped whenever the output register can take a word
   assign pop = ~q_status.empty & (~rsp_valid_ff | rsp_ch.ready);

   // Delay phase counter: a zero setting counts as one tick
   always_comb begin
      n_eff    = (half_ticks_ff == '0) ? 16'd1 : half_ticks_ff;
      dly_done = ({1'b0, delay_ff} + 17'd1) >= {1'b0, n_eff};
      dly_next = dly_done ? '0 : delay_ff + 16'd1;
   end

   // Current bit slot: driven by the master or sampled from the slave
   always_comb begin
      data_slot    = (bit_count_ff < BYTE_BITS);
      slot_written = data_slot != is_read_ff;
      slot_value   = data_slot ? shift_ff[7] : ack_send_ff;
   end

   // Next-state logic for one tick
   always_comb begin
      phase_in     = phase_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      delay_in     = delay_ff;
      open_in      = open_ff;
      scl_low_in   = scl_low_ff;
      sda_low_in   = sda_low_ff;
      rdata_in     = rdata_ff;
      ack_seen_in  = ack_seen_ff;
      is_read_in   = is_read_ff;
      ack_send_in  = ack_send_ff;
      done_in      = 1'b0;
      arb_in       = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            case (head_tick.command)
               CMD_START: begin
                  delay_in = '0;
                  if (open_ff) begin
                     sda_low_in = 1'b0;
                     phase_in   = PH_RS_REL;
                  end else begin
                     arb_in     = ~head_tick.sda_in;
                     sda_low_in = 1'b1;
                     phase_in   = PH_ST_HOLD;
                  end
               end
               CMD_STOP: begin
                  sda_low_in = 1'b1;
                  delay_in   = '0;
                  phase_in   = PH_SP_LOW;
               end
               CMD_WRITE, CMD_READ: begin
                  is_read_in   = (head_tick.command == CMD_READ);
                  ack_send_in  = head_tick.ack_bit;
                  shift_in     = is_read_in ? 8'h00 : head_tick.write_data;
                  bit_count_in = '0;
                  sda_low_in   = bit_sda_low(4'd0, shift_in, is_read_in,
                                             head_tick.ack_bit);
                  delay_in     = '0;
                  phase_in     = PH_BIT_SET;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
         PH_RS_REL: begin
            delay_in = dly_next;
            if (dly_done) begin
               scl_low_in = 1'b0;
               phase_in   = PH_RS_WAIT;
            end
         end
         PH_RS_WAIT: begin
            if (head_tick.scl_in) begin
               delay_in = '0;
               phase_in = PH_RS_SETUP;
            end
         end
         PH_RS_SETUP: begin
            delay_in = dly_next;
            if (dly_done) begin
               arb_in     = ~head_tick.sda_in;
               sda_low_in = 1'b1;
               phase_in   = PH_ST_HOLD;
            end
         end
         PH_ST_HOLD: begin
            delay_in = dly_next;
            if (dly_done) begin
               scl_low_in = 1'b1;
               open_in    = 1'b1;
               done_in    = 1'b1;
               phase_in   = PH_IDLE;
            end
         end
         PH_SP_LOW: begin
            delay_in = dly_next;
            if (dly_done) begin
               scl_low_in = 1'b0;
               phase_in   = PH_SP_WAIT;
            end
         end
         PH_SP_WAIT: begin
            if (head_tick.scl_in) begin
               delay_in = '0;
               phase_in = PH_SP_SETUP;
            end
         end
         PH_SP_SETUP: begin
            delay_in = dly_next;
            if (dly_done) begin
               sda_low_in = 1'b0;
               phase_in   = PH_SP_HIGH;
            end
         end
         PH_SP_HIGH: begin
            delay_in = dly_next;
            if (dly_done) begin
               arb_in   = ~head_tick.sda_in;
               phase_in = PH_SP_END;
            end
         end
         PH_SP_END: begin
            delay_in = dly_next;
            if (dly_done) begin
               open_in  = 1'b0;
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
         end
         PH_BIT_SET: begin
            delay_in = dly_next;
            if (dly_done) begin
               scl_low_in = 1'b0;
               phase_in   = PH_BIT_WAIT;
            end
         end
         PH_BIT_WAIT: begin
            // SCL high (after any stretching): check or sample SDA
            if (head_tick.scl_in) begin
               if (slot_written) begin
                  arb_in = slot_value & ~head_tick.sda_in;
               end else if (data_slot) begin
                  shift_in = {shift_ff[6:0], head_tick.sda_in};
               end else begin
                  ack_seen_in = head_tick.sda_in;
               end
               delay_in = '0;
               phase_in = PH_BIT_HOLD;
            end
         end
         PH_BIT_HOLD: begin
            delay_in = dly_next;
            if (dly_done) begin
               scl_low_in = 1'b1;
               if (!is_read_ff && data_slot) begin
                  shift_in = {shift_ff[6:0], 1'b0};
               end
               bit_count_in = bit_count_ff + 4'd1;
               if (bit_count_in <= BYTE_BITS) begin
                  sda_low_in = bit_sda_low(bit_count_in, shift_in, is_read_ff,
                                           ack_send_ff);
                  phase_in   = PH_BIT_SET;
               end else begin
                  if (is_read_ff) begin
                     rdata_in = shift_in;
                  end
                  bit_count_in = '0;
                  done_in      = 1'b1;
                  phase_in     = PH_IDLE;
               end
            end
         end
         default: begin
            delay_in = '0;
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Sequencer state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         half_ticks_ff <= HALF_BIT_RESET;
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         shift_ff      <= '0;
         delay_ff      <= '0;
         open_ff       <= 1'b0;
         scl_low_ff    <= 1'b0;
         sda_low_ff    <= 1'b0;
         rdata_ff      <= '0;
         ack_seen_ff   <= 1'b0;
         is_read_ff    <= 1'b0;
         ack_send_ff   <= 1'b0;
      end else begin
         if (csr_ch.valid) begin
            half_ticks_ff <= csr_ch.half_bit_ticks;
         end
         if (pop) begin
            phase_ff     <= phase_in;
            bit_count_ff <= bit_count_in;
            shift_ff     <= shift_in;
            delay_ff     <= delay_in;
            open_ff      <= open_in;
            scl_low_ff   <= scl_low_in;
            sda_low_ff   <= sda_low_in;
            rdata_ff     <= rdata_in;
            ack_seen_ff  <= ack_seen_in;
            is_read_ff   <= is_read_in;
            ack_send_ff  <= ack_send_in;
         end
      end
   end

   // Response word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         busy_ff <= (phase_in != PH_IDLE);
         done_ff <= done_in;
         arb_ff  <= arb_in;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.scl_drive_low = scl_low_ff;
   assign rsp_ch.sda_drive_low = sda_low_ff;
   assign rsp_ch.busy_res      = busy_ff;
   assign rsp_ch.done_res      = done_ff;
   assign rsp_ch.read_data     = rdata_ff;
   assign rsp_ch.nack_received = ack_seen_ff;
   assign rsp_ch.arb_lost      = arb_ff;

   a_idle_delay_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (delay_ff == '0))
      else $error("delay counter not clear while idle");
   a_bit_count_range: assert property (@(posedge clock) disable iff (reset)
      bit_count_ff <= BYTE_BITS) else $error("bit counter out of range");
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && done_ff) |-> !busy_ff)
      else $error("done reported while still busy");

endmodule

/* test/i2c_master_bit_engine_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master bit engine: streams tick words,
// predicts every response word and compares it field by field.
// Depends on i2cm_pkg, the channel interfaces in i2cm_if and the engine RTL.
module i2c_master_bit_engine_tb;
   import i2cm_pkg::*;

   localparam int CYCLE_LIMIT   = 4000000;
   localparam int DRAIN_CYCLES  = 10;
   localparam int TICKS_PER_SET = 40;
   localparam int MAX_REPORTS   = 40;
   // how the sampled SDA level is chosen for a run of ticks
   localparam int SDA_LOW       = 0;
   localparam int SDA_HIGH      = 1;
   localparam int SDA_RANDOM    = 2;

   typedef enum logic [3:0] {
      PH_IDLE, PH_RS_REL, PH_RS_WAIT, PH_RS_SETUP, PH_ST_HOLD,
      PH_SP_LOW, PH_SP_WAIT, PH_SP_SETUP, PH_SP_HIGH, PH_SP_END,
      PH_BIT_SET, PH_BIT_WAIT, PH_BIT_HOLD
   } bus_phase_type;

   typedef struct packed {
      logic       scl_low;
      logic       sda_low;
      logic       busy;
      logic       done;
      logic [7:0] rdata;
      logic       nack;
      logic       arb;
   } line_word_type;

   logic clock;
   logic reset;

   i2cm_req_if req_ch ();
   i2cm_rsp_if rsp_ch ();
   i2cm_csr_if csr_ch ();

   i2c_master_bit_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // stimulus and scoreboard storage
   tick_type      tick_q[$];
   line_word_type pending_lines[$];
   tick_type      drive_tick;
   bit            req_fire;
   bit            lines_settled;
   int            burst_left, gap_left;
   logic [15:0]   stall_pat;
   int            stall_age;
   int            cycle_cnt;
   int            fail_count, report_count;
   int            tick_total, words_checked, done_total, arb_total, csr_writes;

   // generator view of the engine, used to size the padding and count queued ticks
   int         gen_half;
   bit         gen_open;
   bit         gen_stretch;
   int         gen_count;

   // predicted engine state
   logic [15:0]   half_bit;
   bus_phase_type ph;
   logic [3:0]    nbits;
   logic [7:0]    shreg;
   logic [7:0]    rx_byte;
   logic [15:0]   dly;
   logic          xfer_open, scl_low, sda_low, ack_seen, rd_mode, ack_out;

   task automatic init_engine();
      half_bit  = HALF_BIT_RESET;
      ph        = PH_IDLE;
      nbits     = '0;
      shreg     = '0;
      rx_byte   = '0;
      dly       = '0;
      xfer_open = 1'b0;
      scl_low   = 1'b0;
      sda_low   = 1'b0;
      ack_seen  = 1'b0;
      rd_mode   = 1'b0;
      ack_out   = 1'b0;
   endtask

   function automatic void go(input bus_phase_type nxt);
      ph  = nxt;
      dly = '0;
   endfunction

   // one delay tick; true once the phase has run its full length (zero acts as one)
   function automatic bit dly_done();
      logic [16:0] lim;
      lim = (half_bit == 16'd0) ? 17'd1 : {1'b0, half_bit};
      if ({1'b0, dly} + 17'd1 >= lim) begin
         dly = '0;
         return 1'b1;
      end
      dly = dly + 16'd1;
      return 1'b0;
   endfunction

   // master drives data bits of a write and the ACK slot of a read
   function automatic bit slot_driven();
      return (nbits < BYTE_BITS) != rd_mode;
   endfunction

   function automatic bit slot_bit();
      return (nbits < BYTE_BITS) ? shreg[7] : ack_out;
   endfunction

   function automatic void begin_bit();
      sda_low = slot_driven() ? !slot_bit() : 1'b0;
      go(PH_BIT_SET);
   endfunction

   // advance the predicted engine by one tick and return the expected word
   function automatic line_word_type predict_tick(input tick_type t);
      line_word_type w;
      logic done, arb;
      done = 1'b0;
      arb  = 1'b0;
      case (ph)
         PH_IDLE: begin
            if (t.command == CMD_START) begin
               if (xfer_open) begin
                  sda_low = 1'b0;
                  go(PH_RS_REL);
               end else begin
                  arb     = !t.sda_in;
                  sda_low = 1'b1;
                  go(PH_ST_HOLD);
               end
            end else if (t.command == CMD_STOP) begin
               sda_low = 1'b1;
               go(PH_SP_LOW);
            end else if (t.command == CMD_WRITE || t.command == CMD_READ) begin
               rd_mode = (t.command == CMD_READ);
               ack_out = t.ack_bit;
               shreg   = rd_mode ? 8'h00 : t.write_data;
               nbits   = '0;
               begin_bit();
            end
         end
         PH_RS_REL: if (dly_done()) begin
            scl_low = 1'b0;
            go(PH_RS_WAIT);
         end
         PH_RS_WAIT: if (t.scl_in) go(PH_RS_SETUP);
         PH_RS_SETUP: if (dly_done()) begin
            arb     = !t.sda_in;
            sda_low = 1'b1;
            go(PH_ST_HOLD);
         end
         PH_ST_HOLD: if (dly_done()) begin
            scl_low   = 1'b1;
            xfer_open = 1'b1;
            done      = 1'b1;
            go(PH_IDLE);
         end
         PH_SP_LOW: if (dly_done()) begin
            scl_low = 1'b0;
            go(PH_SP_WAIT);
         end
         PH_SP_WAIT: if (t.scl_in) go(PH_SP_SETUP);
         PH_SP_SETUP: if (dly_done()) begin
            sda_low = 1'b0;
            go(PH_SP_HIGH);
         end
         PH_SP_HIGH: if (dly_done()) begin
            arb = !t.sda_in;
            go(PH_SP_END);
         end
         PH_SP_END: if (dly_done()) begin
            xfer_open = 1'b0;
            done      = 1'b1;
            go(PH_IDLE);
         end
         PH_BIT_SET: if (dly_done()) begin
            scl_low = 1'b0;
            go(PH_BIT_WAIT);
         end
         PH_BIT_WAIT: if (t.scl_in) begin
            // sample point: check our own bit, or shift in / latch the slave's
            if (slot_driven())
               arb = slot_bit() && !t.sda_in;
            else if (nbits < BYTE_BITS)
               shreg = {shreg[6:0], t.sda_in};
            else
               ack_seen = t.sda_in;
            go(PH_BIT_HOLD);
         end
         PH_BIT_HOLD: if (dly_done()) begin
            scl_low = 1'b1;
            if (!rd_mode && nbits < BYTE_BITS)
               shreg = {shreg[6:0], 1'b0};
            nbits = nbits + 4'd1;
            if (nbits <= BYTE_BITS) begin
               begin_bit();
            end else begin
               if (rd_mode)
                  rx_byte = shreg;
               nbits = '0;
               done  = 1'b1;
               go(PH_IDLE);
            end
         end
         default: go(PH_IDLE);
      endcase
      done_total += int'(done);
      arb_total  += int'(arb);
      w.scl_low = scl_low;
      w.sda_low = sda_low;
      w.busy    = (ph != PH_IDLE);
      w.done    = done;
      w.rdata   = rx_byte;
      w.nack    = ack_seen;
      w.arb     = arb;
      return w;
   endfunction

   function automatic void compare_field(input string fname, input logic [7:0] exp_v,
                                         input logic [7:0] got_v);
      if (exp_v !== got_v) begin
         fail_count++;
         report_count++;
         if (report_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, exp_v, got_v);
      end
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic logic pick_sda(input int mode);
      if (mode == SDA_LOW)
         return 1'b0;
      if (mode == SDA_HIGH)
         return 1'b1;
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic queue_tick(input logic [2:0] cmd, input logic [7:0] data,
                             input logic ack, input logic scl, input logic sda);
      tick_type t;
      t.command    = cmd;
      t.write_data = data;
      t.ack_bit    = ack;
      t.scl_in     = scl;
      t.sda_in     = sda;
      tick_q.push_back(t);
      gen_count++;
   endtask

   // idle ticks: 'need' of them with SCL high, plus random clock-stretch runs
   task automatic pad(input int need, input int sda_mode);
      int run;
      while (need > 0) begin
         if (gen_stretch && $urandom_range(0, 9) == 0) begin
            run = $urandom_range(1, 5);
            repeat (run) queue_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'b0,
                                    pick_sda(sda_mode));
         end
         queue_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'b1, pick_sda(sda_mode));
         need--;
      end
   endtask

   // SCL-high ticks a command needs after it is taken
   function automatic int cmd_ticks(input logic [2:0] cmd);
      int h;
      h = (gen_half == 0) ? 1 : gen_half;
      case (cmd)
         CMD_START:          return gen_open ? 3 * h + 1 : h;
         CMD_STOP:           return 4 * h + 1;
         CMD_WRITE, CMD_READ: return 9 * (2 * h + 1);
         default:            return 0;
      endcase
   endfunction

   task automatic queue_cmd(input logic [2:0] cmd, input logic [7:0] data,
                            input logic ack, input int sda_mode);
      int need;
      need = cmd_ticks(cmd) + $urandom_range(0, 2);
      if (cmd == CMD_START)
         gen_open = 1'b1;
      if (cmd == CMD_STOP)
         gen_open = 1'b0;
      queue_tick(cmd, data, ack, 1'b1, pick_sda(sda_mode));
      pad(need, sda_mode);
   endtask

   // mostly complete transfers with random content, some unaligned noise
   task automatic queue_sequence();
      int n_bytes;
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            queue_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 1'b1,
                       1'($urandom_range(0, 1)));
            pad($urandom_range(0, 12), SDA_RANDOM);
         end
         gen_open = 1'b1;
      end else begin
         queue_cmd(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM);
         n_bytes = $urandom_range(1, 3);
         repeat (n_bytes)
            queue_cmd($urandom_range(0, 1) ? CMD_WRITE : CMD_READ, 8'($urandom),
                      1'($urandom), SDA_RANDOM);
         if ($urandom_range(0, 3) == 0) begin
            queue_cmd(CMD_START, 8'($urandom), 1'($urandom), SDA_RANDOM);
            queue_cmd(CMD_READ, 8'($urandom), 1'($urandom), SDA_RANDOM);
         end
         if ($urandom_range(0, 4) != 0)
            queue_cmd(CMD_STOP, 8'($urandom), 1'($urandom), SDA_RANDOM);
      end
   endtask

   // wait for the stream to drain; keep ticking until the engine is idle
   task automatic settle_engine();
      bit idle;
      idle = 1'b0;
      while (!idle) begin
         do @(negedge clock); while (!lines_settled || tick_q.size() != 0);
         if (ph == PH_IDLE)
            idle = 1'b1;
         else
            pad(8, SDA_RANDOM);
      end
   endtask

   task automatic write_half_bit(input logic [15:0] v);
      @(negedge clock);
      csr_ch.half_bit_ticks <= v;
      csr_ch.valid          <= 1'b1;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      gen_half = int'(v);
      csr_writes++;
   endtask

   // ---------------- clock and driver ----------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // request driver: bursts of words separated by random gaps
   always @(negedge clock) begin
      if (!reset && (!req_ch.valid || req_fire)) begin
         req_fire = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            req_ch.valid <= 1'b0;
         end else if (tick_q.size() > 0) begin
            drive_tick = tick_q.pop_front();
            req_ch.command    <= drive_tick.command;
            req_ch.write_data <= drive_tick.write_data;
            req_ch.ack_bit    <= drive_tick.ack_bit;
            req_ch.scl_in     <= drive_tick.scl_in;
            req_ch.sda_in     <= drive_tick.sda_in;
            req_ch.valid      <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            end
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response stall pattern, re-chosen whenever its random age runs out
   always @(negedge clock) begin
      if (stall_age == 0) begin
         stall_age = $urandom_range(50, 300);
         case ($urandom_range(0, 2))
            0:       stall_pat = 16'hFFFF;
            1:       stall_pat = 16'($urandom | 16'h1111);
            default: stall_pat = 16'(($urandom & $urandom) | 16'h0101);
         endcase
      end else begin
         stall_age--;
      end
      stall_pat = {stall_pat[0], stall_pat[15:1]};
      rsp_ch.ready <= stall_pat[0];
   end

   // ---------------- monitor and checker ----------------
   always @(posedge clock) begin
      tick_type      t;
      line_word_type e;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            half_bit = csr_ch.half_bit_ticks;
         if (req_ch.valid && req_ch.ready) begin
            t.command    = req_ch.command;
            t.write_data = req_ch.write_data;
            t.ack_bit    = req_ch.ack_bit;
            t.scl_in     = req_ch.scl_in;
            t.sda_in     = req_ch.sda_in;
            pending_lines.push_back(predict_tick(t));
            req_fire = 1'b1;
            tick_total++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_lines.size() == 0) begin
               fail_count++;
               report_count++;
               if (report_count <= MAX_REPORTS)
                  $display("%0t: response word with none expected", $time);
            end else begin
               e = pending_lines.pop_front();
               compare_field("scl_drive_low", 8'(e.scl_low), 8'(rsp_ch.scl_drive_low));
               compare_field("sda_drive_low", 8'(e.sda_low), 8'(rsp_ch.sda_drive_low));
               compare_field("busy_res", 8'(e.busy), 8'(rsp_ch.busy_res));
               compare_field("done_res", 8'(e.done), 8'(rsp_ch.done_res));
               compare_field("read_data", e.rdata, rsp_ch.read_data);
               compare_field("nack_received", 8'(e.nack), 8'(rsp_ch.nack_received));
               compare_field("arb_lost", 8'(e.arb), 8'(rsp_ch.arb_lost));
               words_checked++;
            end
         end
      end
      lines_settled = (pending_lines.size() == 0) && !req_ch.valid;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
         $display("FAIL i2c_master_bit_engine");
         $finish;
      end
   end

   // ---------------- test sequence ----------------
   initial begin
      int half_plan[$];
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.command        = CMD_NONE;
      req_ch.write_data     = '0;
      req_ch.ack_bit        = 1'b0;
      req_ch.scl_in         = 1'b1;
      req_ch.sda_in         = 1'b1;
      rsp_ch.ready          = 1'b0;
      csr_ch.valid          = 1'b0;
      csr_ch.half_bit_ticks = '0;
      req_fire      = 1'b0;
      lines_settled = 1'b0;
      burst_left    = 0;
      gap_left      = 0;
      stall_age     = 0;
      stall_pat     = 16'hFFFF;
      gen_half      = int'(HALF_BIT_RESET);
      gen_open      = 1'b0;
      gen_stretch   = 1'b1;
      init_engine();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset half-bit count: open a transfer from a closed bus
      queue_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM);
      settle_engine();

      // directed cases at the shortest nonzero half bit
      write_half_bit(16'd1);
      queue_cmd(CMD_STOP, 8'h00, 1'b0, SDA_HIGH);        // close the open transfer
      queue_cmd(CMD_START, 8'h00, 1'b0, SDA_LOW);        // start with SDA held low
      queue_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW);        // every released bit lost
      queue_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH);       // slave NACKs
      queue_cmd(CMD_READ, 8'h00, 1'b1, SDA_HIGH);        // all ones, we NACK
      queue_cmd(CMD_READ, 8'hFF, 1'b0, SDA_LOW);         // all zeros, we ACK
      queue_cmd(CMD_START, 8'h00, 1'b0, SDA_LOW);        // repeated start, SDA low
      queue_tick(3'd7, 8'hFF, 1'b1, 1'b1, 1'b1);        // unused codes do nothing
      queue_tick(3'd5, 8'h00, 1'b0, 1'b0, 1'b0);
      // command arriving while a byte is in flight is dropped
      queue_tick(CMD_WRITE, 8'h5A, 1'b0, 1'b1, 1'b1);
      queue_tick(CMD_READ, 8'hA5, 1'b1, 1'b1, 1'b0);
      pad(cmd_ticks(CMD_WRITE), SDA_RANDOM);
      queue_cmd(CMD_STOP, 8'h00, 1'b0, SDA_LOW);         // stop with SDA held low
      queue_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM);     // byte with no transfer open
      queue_cmd(CMD_READ, 8'h00, 1'b1, SDA_RANDOM);
      queue_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);
      queue_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM);      // stop on a closed bus
      settle_engine();

      // random transfers across several half-bit settings, zero among them
      half_plan = '{0, 1, 2, 0, 3};
      half_plan[4] = $urandom_range(2, 3);
      foreach (half_plan[i]) begin
         write_half_bit(16'(half_plan[i]));
         gen_count = 0;
         while (gen_count < TICKS_PER_SET)
            queue_sequence();
         settle_engine();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_lines.size() != 0) begin
         fail_count++;
         $display("%0t: %0d expected words never arrived", $time, pending_lines.size());
      end
      $display("Ran %0d ticks over %0d half-bit settings; %0d words checked,",
               tick_total, csr_writes + 1, words_checked);
      $display("%0d commands finished, %0d arbitration flags, %0d mismatches.",
               done_total, arb_total, fail_count);
      if (fail_count == 0)
         $display("PASS i2c_master_bit_engine");
      else
         $display("FAIL i2c_master_bit_engine");
      $finish;
   end

endmodule

/* files.f */
design/i2cm_pkg.sv
design/i2cm_if.sv
design/i2cm_front.sv
design/i2cm_queue.sv
design/i2cm_back.sv
design/i2c_master_bit_engine.sv
test/i2c_master_bit_engine_tb.sv
